// ----- sv/cjd_pkg.sv -----
// Shared types and constants of the cascaded joint delay line.
`timescale 1ns / 1ps

package cjd_pkg;

    // Number of parallel delay channels: bias, curv, pitch, yaw, torsion, phase, hyper
    localparam int CHANNELS = 7;

    // Channel carrying phase, and the one it may borrow from
    localparam int PHASE_CH = 5;
    localparam int HYPER_CH = 6;

    // Fixed port field widths
    localparam int FIELD_WIDTH     = 32;
    localparam int POS_WIDTH       = 5;
    localparam int CFG_WIDTH       = 6;
    localparam int CFG_INDEX_WIDTH = 2;

    // Register reset values
    localparam logic [CFG_WIDTH-1:0] RESET_JOINTS = 6'd16;
    localparam logic [CFG_WIDTH-1:0] RESET_HOLD   = 6'd28;

    // Register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_JOINT_COUNT = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_HOLD_LENGTH = 2'd1;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SHIFT,
        ST_EMIT
    } state_t;

    // Status of the delay store walker
    typedef struct packed {
        logic clear_busy;
        logic walk_done;
    } shift_stat_t;

    // Command to the result drain
    typedef struct packed {
        logic start;
        logic reverse;
    } emit_cmd_t;

    // Status of the result drain
    typedef struct packed {
        logic busy;
    } emit_stat_t;

endpackage

// ----- sv/cjd_item_if.sv -----
// Input item channel: seven words, channel mask and order selects.
`timescale 1ns / 1ps

interface cjd_item_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [cjd_pkg::FIELD_WIDTH-1:0] bias_value;
    logic signed [cjd_pkg::FIELD_WIDTH-1:0] curvature_value;
    logic signed [cjd_pkg::FIELD_WIDTH-1:0] curvature_zero_pitch;
    logic signed [cjd_pkg::FIELD_WIDTH-1:0] curvature_zero_yaw;
    logic signed [cjd_pkg::FIELD_WIDTH-1:0] torsion_value;
    logic signed [cjd_pkg::FIELD_WIDTH-1:0] phase_value;
    logic signed [cjd_pkg::FIELD_WIDTH-1:0] hyper_phase_value;
    logic [cjd_pkg::CHANNELS-1:0]           channel_mask;
    logic                                  reverse_order;
    logic                                  phase_from_hyper;

    modport source (
        output valid, bias_value, curvature_value, curvature_zero_pitch,
               curvature_zero_yaw, torsion_value, phase_value, hyper_phase_value,
               channel_mask, reverse_order, phase_from_hyper,
        input  ready
    );

    modport sink (
        input  valid, bias_value, curvature_value, curvature_zero_pitch,
               curvature_zero_yaw, torsion_value, phase_value, hyper_phase_value,
               channel_mask, reverse_order, phase_from_hyper,
        output ready
    );
endinterface

// ----- sv/cjd_result_if.sv -----
// Result channel: one word per joint with position, mask copy and last flag.
`timescale 1ns / 1ps

interface cjd_result_if;
    logic                                  valid;
    logic                                  ready;
    logic [cjd_pkg::POS_WIDTH-1:0]          position;
    logic signed [cjd_pkg::FIELD_WIDTH-1:0] bias_out;
    logic signed [cjd_pkg::FIELD_WIDTH-1:0] curvature_out;
    logic signed [cjd_pkg::FIELD_WIDTH-1:0] zero_pitch_out;
    logic signed [cjd_pkg::FIELD_WIDTH-1:0] zero_yaw_out;
    logic signed [cjd_pkg::FIELD_WIDTH-1:0] torsion_out;
    logic signed [cjd_pkg::FIELD_WIDTH-1:0] phase_out;
    logic signed [cjd_pkg::FIELD_WIDTH-1:0] hyper_phase_out;
    logic [cjd_pkg::CHANNELS-1:0]           updated_mask;
    logic                                  last;

    modport source (
        output valid, position, bias_out, curvature_out, zero_pitch_out,
               zero_yaw_out, torsion_out, phase_out, hyper_phase_out,
               updated_mask, last,
        input  ready
    );

    modport sink (
        input  valid, position, bias_out, curvature_out, zero_pitch_out,
               zero_yaw_out, torsion_out, phase_out, hyper_phase_out,
               updated_mask, last,
        output ready
    );
endinterface

// ----- sv/cjd_cfg_if.sv -----
// Configuration write channel: register index and write data.
`timescale 1ns / 1ps

interface cjd_cfg_if;
    logic                                  valid;
    logic                                  ready;
    logic [cjd_pkg::CFG_INDEX_WIDTH-1:0]    index;
    logic [cjd_pkg::CFG_WIDTH-1:0]          data;

    modport source (
        output valid, index, data,
        input  ready
    );

    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

// ----- sv/cjd_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module cjd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- sv/cjd_shift.sv -----
// Delay store walker: clears the store after reset and shifts words joint by joint.
`timescale 1ns / 1ps

module cjd_shift #(
    parameter int MAX_JOINTS = 32,
    parameter int MAX_HOLD   = 32,
    parameter int WORD_WIDTH = 32,
    localparam int JW  = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1,
    localparam int HW  = (MAX_HOLD > 1) ? $clog2(MAX_HOLD) : 1,
    localparam int JCW = $clog2(MAX_JOINTS + 1),
    localparam int CH  = cjd_pkg::CHANNELS
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [JCW-1:0]          nj,
    input  logic [CH-1:0]           mask,
    input  logic [WORD_WIDTH-1:0]   words [CH],
    input  logic [HW-1:0]           slots [CH],
    output cjd_pkg::shift_stat_t    status,
    output logic                    buf_we,
    output logic [JW-1:0]           buf_waddr,
    output logic [CH*WORD_WIDTH-1:0] buf_wdata
);

    localparam int AW = JW + HW;

    logic                  clearing_reg;
    logic [AW-1:0]         clear_addr_reg;
    logic                  walking_reg;
    logic [JW-1:0]         rd_joint_reg;
    logic                  wb_valid_reg;
    logic [JW-1:0]         wb_joint_reg;
    logic [JW-1:0]         last_joint_reg;
    logic [CH-1:0]         mask_reg;
    logic [HW-1:0]         slot_reg  [CH];
    logic [WORD_WIDTH-1:0] carry_reg [CH];
    logic [WORD_WIDTH-1:0] rd_data   [CH];
    logic [JCW-1:0]        nj_m1;

    assign nj_m1 = nj - JCW'(1);

    // Sweep the store to zero after reset, one row of all banks a cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg   <= 1'b1;
            clear_addr_reg <= '0;
        end
        else if (clearing_reg)
        begin
            clear_addr_reg <= clear_addr_reg + AW'(1);
            if (&clear_addr_reg)
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    // Advance the read side through the joints and follow with write-back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walking_reg  <= 1'b0;
            wb_valid_reg <= 1'b0;
        end
        else
        begin
            wb_valid_reg <= walking_reg;
            if (start)
            begin
                walking_reg <= 1'b1;
            end
            else if (walking_reg && (rd_joint_reg == last_joint_reg))
            begin
                walking_reg <= 1'b0;
            end
        end
    end

    // Hold the item words, slots and counters
    always_ff @(posedge clk)
    begin
        wb_joint_reg <= rd_joint_reg;
        if (start)
        begin
            rd_joint_reg   <= '0;
            last_joint_reg <= JW'(nj_m1);
            mask_reg       <= mask;
            for (int c = 0; c < CH; c++)
            begin
                slot_reg[c]  <= slots[c];
                carry_reg[c] <= words[c];
            end
        end
        else
        begin
            if (walking_reg)
            begin
                rd_joint_reg <= rd_joint_reg + JW'(1);
            end
            if (wb_valid_reg)
            begin
                // the oldest word of this joint moves on to the next joint
                for (int c = 0; c < CH; c++)
                begin
                    carry_reg[c] <= rd_data[c];
                end
            end
        end
    end

    // One bank per channel, each channel on its own slot
    for (genvar c = 0; c < CH; c++)
    begin : g_bank
        logic          bank_we;
        logic [AW-1:0] bank_waddr;
        logic [WORD_WIDTH-1:0] bank_wdata;

        always_comb
        begin
            if (clearing_reg)
            begin
                bank_we    = 1'b1;
                bank_waddr = clear_addr_reg;
                bank_wdata = '0;
            end
            else
            begin
                bank_we    = wb_valid_reg && mask_reg[c];
                bank_waddr = {wb_joint_reg, slot_reg[c]};
                bank_wdata = carry_reg[c];
            end
        end

        cjd_ram #(
            .WIDTH (WORD_WIDTH),
            .DEPTH (2 ** AW)
        ) u_bank (
            .clk   (clk),
            .we    (bank_we),
            .waddr (bank_waddr),
            .wdata (bank_wdata),
            .re    (walking_reg),
            .raddr ({rd_joint_reg, slot_reg[c]}),
            .rdata (rd_data[c])
        );

        // Emitted word of this joint, zero on channels left alone
        assign buf_wdata[c*WORD_WIDTH +: WORD_WIDTH] = mask_reg[c] ? rd_data[c] : '0;
    end

    assign buf_we            = wb_valid_reg;
    assign buf_waddr         = wb_joint_reg;
    assign status.clear_busy = clearing_reg;
    assign status.walk_done  = wb_valid_reg && (wb_joint_reg == last_joint_reg);

endmodule

// ----- sv/cjd_emit.sv -----
// Result drain: joint result buffer read in output order through an output and skid register.
`timescale 1ns / 1ps

module cjd_emit #(
    parameter int MAX_JOINTS = 32,
    parameter int WORD_WIDTH = 32,
    localparam int JW  = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1,
    localparam int JCW = $clog2(MAX_JOINTS + 1),
    localparam int CH  = cjd_pkg::CHANNELS
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  cjd_pkg::emit_cmd_t       cmd,
    input  logic [JCW-1:0]           nj,
    input  logic [CH-1:0]            mask,
    input  logic                     buf_we,
    input  logic [JW-1:0]            buf_waddr,
    input  logic [CH*WORD_WIDTH-1:0] buf_wdata,
    output cjd_pkg::emit_stat_t      status,
    cjd_result_if.source             result
);

    localparam int DW = CH * WORD_WIDTH;

    logic            draining_reg;
    logic [JW-1:0]   k_reg;
    logic [JW-1:0]   last_joint_reg;
    logic            rev_reg;
    logic [CH-1:0]   mask_reg;
    logic [JCW-1:0]  nj_m1;

    logic            pend_reg;
    logic [JW-1:0]   pend_pos_reg;
    logic            pend_last_reg;
    logic [CH-1:0]   pend_mask_reg;
    logic [DW-1:0]   rd_data;

    logic            out_valid_reg;
    logic [JW-1:0]   out_pos_reg;
    logic            out_last_reg;
    logic [CH-1:0]   out_mask_reg;
    logic [DW-1:0]   out_data_reg;

    logic            skid_valid_reg;
    logic [JW-1:0]   skid_pos_reg;
    logic            skid_last_reg;
    logic [CH-1:0]   skid_mask_reg;
    logic [DW-1:0]   skid_data_reg;

    logic            fire;
    logic [1:0]      used;
    logic [1:0]      used_after;
    logic            issue;
    logic [JW-1:0]   raddr;

    assign nj_m1 = nj - JCW'(1);

    // Issue a read only when a slot is sure to be free for its word
    assign fire       = out_valid_reg && result.ready;
    assign used       = 2'(out_valid_reg) + 2'(skid_valid_reg) + 2'(pend_reg);
    assign used_after = used - 2'(fire);
    assign issue      = draining_reg && (used_after < 2'd2);
    assign raddr      = rev_reg ? (last_joint_reg - k_reg) : k_reg;

    cjd_ram #(
        .WIDTH (DW),
        .DEPTH (2 ** JW)
    ) u_result_buf (
        .clk   (clk),
        .we    (buf_we),
        .waddr (buf_waddr),
        .wdata (buf_wdata),
        .re    (issue),
        .raddr (raddr),
        .rdata (rd_data)
    );

    // Drain sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            draining_reg <= 1'b0;
            pend_reg     <= 1'b0;
        end
        else
        begin
            pend_reg <= issue;
            if (cmd.start)
            begin
                draining_reg <= 1'b1;
            end
            else if (issue && (k_reg == last_joint_reg))
            begin
                draining_reg <= 1'b0;
            end
        end
    end

    // Hold drain order and tag each read
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            k_reg          <= '0;
            last_joint_reg <= JW'(nj_m1);
            rev_reg        <= cmd.reverse;
            mask_reg       <= mask;
        end
        else if (issue)
        begin
            k_reg <= k_reg + JW'(1);
        end
        if (issue)
        begin
            pend_pos_reg  <= k_reg;
            pend_last_reg <= (k_reg == last_joint_reg);
            pend_mask_reg <= mask_reg;
        end
    end

    // Output and skid valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (fire || !out_valid_reg)
        begin
            out_valid_reg  <= skid_valid_reg || pend_reg;
            skid_valid_reg <= skid_valid_reg && pend_reg;
        end
        else if (pend_reg)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Output and skid payload
    always_ff @(posedge clk)
    begin
        if (fire || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_pos_reg   <= skid_pos_reg;
                out_last_reg  <= skid_last_reg;
                out_mask_reg  <= skid_mask_reg;
                out_data_reg  <= skid_data_reg;
                skid_pos_reg  <= pend_pos_reg;
                skid_last_reg <= pend_last_reg;
                skid_mask_reg <= pend_mask_reg;
                skid_data_reg <= rd_data;
            end
            else
            begin
                out_pos_reg  <= pend_pos_reg;
                out_last_reg <= pend_last_reg;
                out_mask_reg <= pend_mask_reg;
                out_data_reg <= rd_data;
            end
        end
        else if (pend_reg)
        begin
            skid_pos_reg  <= pend_pos_reg;
            skid_last_reg <= pend_last_reg;
            skid_mask_reg <= pend_mask_reg;
            skid_data_reg <= rd_data;
        end
    end

    // Drive the result word
    assign result.valid           = out_valid_reg;
    assign result.position        = cjd_pkg::POS_WIDTH'(out_pos_reg);
    assign result.bias_out        = 32'(out_data_reg[0*WORD_WIDTH +: WORD_WIDTH]);
    assign result.curvature_out   = 32'(out_data_reg[1*WORD_WIDTH +: WORD_WIDTH]);
    assign result.zero_pitch_out  = 32'(out_data_reg[2*WORD_WIDTH +: WORD_WIDTH]);
    assign result.zero_yaw_out    = 32'(out_data_reg[3*WORD_WIDTH +: WORD_WIDTH]);
    assign result.torsion_out     = 32'(out_data_reg[4*WORD_WIDTH +: WORD_WIDTH]);
    assign result.phase_out       = 32'(out_data_reg[5*WORD_WIDTH +: WORD_WIDTH]);
    assign result.hyper_phase_out = 32'(out_data_reg[6*WORD_WIDTH +: WORD_WIDTH]);
    assign result.updated_mask    = out_mask_reg;
    assign result.last            = out_last_reg;

    assign status.busy = draining_reg;

endmodule

// ----- sv/cascaded_joint_delay_line.sv -----
// Cascaded joint delay line: seven delay channels carried down a chain of joints.
// Each accepted word is processed in full before the next is taken:
// one read-modify-write of the delay store per joint, then one result buffer read per joint.
// Results come out once the walk through the delay store has finished.
// After reset a clearing pass zeroes every row of the store, one row of all banks at a time;
// no word is accepted until it ends.
`timescale 1ns / 1ps

module cascaded_joint_delay_line #(
    parameter int MAX_JOINTS = 32,
    parameter int MAX_HOLD   = 32,
    parameter int WORD_WIDTH = 32
) (
    input logic          clk,
    input logic          rst_n,
    cjd_item_if.sink     item,
    cjd_result_if.source result,
    cjd_cfg_if.sink      cfg
);

    localparam int JW  = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
    localparam int HW  = (MAX_HOLD > 1) ? $clog2(MAX_HOLD) : 1;
    localparam int JCW = $clog2(MAX_JOINTS + 1);
    localparam int HCW = $clog2(MAX_HOLD + 1);
    localparam int CH  = cjd_pkg::CHANNELS;

    cjd_pkg::state_t      state_reg;
    cjd_pkg::state_t      state_next;
    cjd_pkg::shift_stat_t shift_stat;
    cjd_pkg::emit_stat_t  emit_stat;
    cjd_pkg::emit_cmd_t   emit_cmd;

    logic [cjd_pkg::CFG_WIDTH-1:0] joint_count_reg;
    logic [cjd_pkg::CFG_WIDTH-1:0] hold_length_reg;
    logic [HW-1:0]                 slot_ptr_reg [CH];
    logic [HW-1:0]                 slot_eff     [CH];
    logic [HW-1:0]                 slot_inc     [CH];
    logic [WORD_WIDTH-1:0]         words        [CH];
    logic [JCW-1:0]                nj_eff;
    logic [HCW-1:0]                nh_eff;
    logic                          accept;
    logic                          shift_start;
    logic                          rev_reg;
    logic [CH-1:0]                 mask_reg;

    logic                          buf_we;
    logic [JW-1:0]                 buf_waddr;
    logic [CH*WORD_WIDTH-1:0]      buf_wdata;

    // Effective joint count and hold length: zero taken as one, clamped to the store size
    always_comb
    begin
        if (joint_count_reg == '0)
        begin
            nj_eff = JCW'(1);
        end
        else if (int'(joint_count_reg) > MAX_JOINTS)
        begin
            nj_eff = JCW'(MAX_JOINTS);
        end
        else
        begin
            nj_eff = JCW'(joint_count_reg);
        end

        if (hold_length_reg == '0)
        begin
            nh_eff = HCW'(1);
        end
        else if (int'(hold_length_reg) > MAX_HOLD)
        begin
            nh_eff = HCW'(MAX_HOLD);
        end
        else
        begin
            nh_eff = HCW'(hold_length_reg);
        end
    end

    // Oldest slot of each channel and its successor modulo the hold length
    always_comb
    begin
        for (int c = 0; c < CH; c++)
        begin
            slot_eff[c] = (int'(slot_ptr_reg[c]) >= int'(nh_eff)) ? '0 : slot_ptr_reg[c];
            slot_inc[c] = ((int'(slot_eff[c]) + 1) >= int'(nh_eff)) ? '0
                                                                     : slot_eff[c] + HW'(1);
        end
    end

    // Words entering the head joint
    assign words[0] = WORD_WIDTH'($unsigned(item.bias_value));
    assign words[1] = WORD_WIDTH'($unsigned(item.curvature_value));
    assign words[2] = WORD_WIDTH'($unsigned(item.curvature_zero_pitch));
    assign words[3] = WORD_WIDTH'($unsigned(item.curvature_zero_yaw));
    assign words[4] = WORD_WIDTH'($unsigned(item.torsion_value));
    assign words[cjd_pkg::PHASE_CH] = item.phase_from_hyper
                                      ? WORD_WIDTH'($unsigned(item.hyper_phase_value))
                                      : WORD_WIDTH'($unsigned(item.phase_value));
    assign words[cjd_pkg::HYPER_CH] = WORD_WIDTH'($unsigned(item.hyper_phase_value));

    assign accept    = item.valid && item.ready;
    assign cfg.ready = 1'b1;

    // Configuration registers and slot pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            joint_count_reg <= cjd_pkg::RESET_JOINTS;
            hold_length_reg <= cjd_pkg::RESET_HOLD;
            for (int c = 0; c < CH; c++)
            begin
                slot_ptr_reg[c] <= '0;
            end
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                cjd_pkg::REG_JOINT_COUNT:
                begin
                    joint_count_reg <= cfg.data;
                end
                cjd_pkg::REG_HOLD_LENGTH:
                begin
                    hold_length_reg <= cfg.data;
                    // rewind every channel
                    for (int c = 0; c < CH; c++)
                    begin
                        slot_ptr_reg[c] <= '0;
                    end
                end
                default:
                begin
                    // drop writes to unknown registers
                end
            endcase
        end
        else if (accept)
        begin
            for (int c = 0; c < CH; c++)
            begin
                if (item.channel_mask[c])
                begin
                    slot_ptr_reg[c] <= slot_inc[c];
                end
            end
        end
    end

    // Hold the order selects for the drain
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rev_reg  <= item.reverse_order;
            mask_reg <= item.channel_mask;
        end
    end

    // Sequencer state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cjd_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cjd_pkg::ST_CLEAR:
            begin
                if (!shift_stat.clear_busy)
                begin
                    state_next = cjd_pkg::ST_IDLE;
                end
            end
            cjd_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = cjd_pkg::ST_SHIFT;
                end
            end
            cjd_pkg::ST_SHIFT:
            begin
                if (shift_stat.walk_done)
                begin
                    state_next = cjd_pkg::ST_EMIT;
                end
            end
            cjd_pkg::ST_EMIT:
            begin
                if (!emit_stat.busy)
                begin
                    state_next = cjd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cjd_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs; a register write takes priority over a new word in the same cycle
    always_comb
    begin
        item.ready       = 1'b0;
        emit_cmd.start   = 1'b0;
        emit_cmd.reverse = rev_reg;
        case (state_reg)
            cjd_pkg::ST_IDLE:
            begin
                item.ready = !cfg.valid;
            end
            cjd_pkg::ST_SHIFT:
            begin
                emit_cmd.start = shift_stat.walk_done;
            end
            default:
            begin
                item.ready = 1'b0;
            end
        endcase
    end

    assign shift_start = accept;

    cjd_shift #(
        .MAX_JOINTS (MAX_JOINTS),
        .MAX_HOLD   (MAX_HOLD),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_shift (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (shift_start),
        .nj        (nj_eff),
        .mask      (item.channel_mask),
        .words     (words),
        .slots     (slot_eff),
        .status    (shift_stat),
        .buf_we    (buf_we),
        .buf_waddr (buf_waddr),
        .buf_wdata (buf_wdata)
    );

    cjd_emit #(
        .MAX_JOINTS (MAX_JOINTS),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (emit_cmd),
        .nj        (nj_eff),
        .mask      (mask_reg),
        .buf_we    (buf_we),
        .buf_waddr (buf_waddr),
        .buf_wdata (buf_wdata),
        .status    (emit_stat),
        .result    (result)
    );

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the cascaded joint delay line: random and directed words, scoreboard.
`timescale 1ns / 1ps

module tb_top;

    // Chain sizes the block is built with
    localparam int JOINT_LIMIT = 32;
    localparam int HOLD_LIMIT  = 32;

    // Register indexes the block does not decode
    localparam logic [cjd_pkg::CFG_INDEX_WIDTH-1:0] REG_SPARE_A = 2'd2;
    localparam logic [cjd_pkg::CFG_INDEX_WIDTH-1:0] REG_SPARE_B = 2'd3;

    // Clearing pass plus the long receiver hold-off, with margin to spare
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int TAIL_CYCLES     = 100;

    typedef struct packed {
        logic [cjd_pkg::CHANNELS-1:0][cjd_pkg::FIELD_WIDTH-1:0] words;
        logic [cjd_pkg::CHANNELS-1:0]                           mask;
        logic                                                   rev;
        logic                                                   from_hyper;
    } shape_item_t;

    typedef struct packed {
        logic [cjd_pkg::POS_WIDTH-1:0]                          position;
        logic [cjd_pkg::CHANNELS-1:0][cjd_pkg::FIELD_WIDTH-1:0] words;
        logic [cjd_pkg::CHANNELS-1:0]                           mask;
        logic                                                   last;
    } joint_result_t;

    // Mirror of the joint chain and queue of the joint words still to come out
    class joint_delay_scoreboard;
        logic [cjd_pkg::FIELD_WIDTH-1:0] store [cjd_pkg::CHANNELS][JOINT_LIMIT][HOLD_LIMIT];
        int                              slot [cjd_pkg::CHANNELS];
        logic [cjd_pkg::CFG_WIDTH-1:0]   joint_count;
        logic [cjd_pkg::CFG_WIDTH-1:0]   hold_length;
        joint_result_t                   joint_q[$];
        int                              errors;
        string chan_name [cjd_pkg::CHANNELS] = '{"bias", "curvature", "zero_pitch", "zero_yaw",
                                                 "torsion", "phase", "hyper_phase"};

        function new();
            foreach (store[c, j, h])
                store[c][j][h] = '0;
            foreach (slot[c])
                slot[c] = 0;
            joint_count = cjd_pkg::RESET_JOINTS;
            hold_length = cjd_pkg::RESET_HOLD;
            errors      = 0;
        endfunction

        function int pending();
            return joint_q.size();
        endfunction

        // Apply a register write; a new hold length rewinds every channel
        function void write_reg(logic [cjd_pkg::CFG_INDEX_WIDTH-1:0] idx,
                                logic [cjd_pkg::CFG_WIDTH-1:0] data);
            case (idx)
                cjd_pkg::REG_JOINT_COUNT: joint_count = data;
                cjd_pkg::REG_HOLD_LENGTH:
                begin
                    hold_length = data;
                    foreach (slot[c])
                        slot[c] = 0;
                end
                default: ;
            endcase
        endfunction

        // Shift the selected channels down the chain and queue one word per joint
        function void note_shape(shape_item_t it);
            logic [cjd_pkg::FIELD_WIDTH-1:0] tap [JOINT_LIMIT][cjd_pkg::CHANNELS];
            logic [cjd_pkg::FIELD_WIDTH-1:0] carry;
            logic [cjd_pkg::FIELD_WIDTH-1:0] oldest;
            int                              nj;
            int                              nh;
            int                              p;
            int                              src;
            joint_result_t                   r;
            nj = joint_count;
            if (nj == 0) nj = 1;
            if (nj > JOINT_LIMIT) nj = JOINT_LIMIT;
            nh = hold_length;
            if (nh == 0) nh = 1;
            if (nh > HOLD_LIMIT) nh = HOLD_LIMIT;
            foreach (tap[j, c])
                tap[j][c] = '0;
            for (int c = 0; c < cjd_pkg::CHANNELS; c++)
            begin
                if (!it.mask[c]) continue;
                carry = (c == cjd_pkg::PHASE_CH && it.from_hyper) ? it.words[cjd_pkg::HYPER_CH]
                                                                  : it.words[c];
                p = slot[c];
                if (p >= nh) p = 0;
                for (int j = 0; j < nj; j++)
                begin
                    oldest          = store[c][j][p];
                    store[c][j][p]  = carry;
                    tap[j][c]       = oldest;
                    carry           = oldest;
                end
                p++;
                if (p >= nh) p = 0;
                slot[c] = p;
            end
            for (int k = 0; k < nj; k++)
            begin
                src        = it.rev ? (nj - 1 - k) : k;
                r.position = cjd_pkg::POS_WIDTH'(k);
                for (int c = 0; c < cjd_pkg::CHANNELS; c++)
                    r.words[c] = tap[src][c];
                r.mask = it.mask;
                r.last = (k == nj - 1);
                joint_q.insert(joint_q.size(), r);
            end
        endfunction

        function void flag(string what, logic [cjd_pkg::FIELD_WIDTH-1:0] want,
                           logic [cjd_pkg::FIELD_WIDTH-1:0] got);
            errors++;
            $display("%0t ns: %s expected %h got %h", $time, what, want, got);
        endfunction

        // Compare one joint word against the oldest one outstanding
        function void check_joint(joint_result_t got);
            joint_result_t want;
            if (joint_q.size() == 0)
            begin
                errors++;
                $display("%0t ns: joint word at position %0d expected none got one",
                         $time, got.position);
                return;
            end
            want = joint_q.pop_front();
            if (got.position !== want.position)
                flag("position", cjd_pkg::FIELD_WIDTH'(want.position),
                     cjd_pkg::FIELD_WIDTH'(got.position));
            for (int c = 0; c < cjd_pkg::CHANNELS; c++)
                if (got.words[c] !== want.words[c])
                    flag(chan_name[c], want.words[c], got.words[c]);
            if (got.mask !== want.mask)
                flag("updated_mask", cjd_pkg::FIELD_WIDTH'(want.mask),
                     cjd_pkg::FIELD_WIDTH'(got.mask));
            if (got.last !== want.last)
                flag("last", cjd_pkg::FIELD_WIDTH'(want.last), cjd_pkg::FIELD_WIDTH'(got.last));
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   send_idle_pct;
    int   recv_stall_pct;
    int   hold_off_asked;
    int   quiet_cycles = 0;

    joint_delay_scoreboard sb = new();

    cjd_item_if   item_bus ();
    cjd_result_if result_bus ();
    cjd_cfg_if    cfg_bus ();

    cascaded_joint_delay_line u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_bus),
        .result (result_bus),
        .cfg    (cfg_bus)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Receiver: random stalls, plus a long hold-off whenever one is asked for
    initial
    begin
        int served;
        served           = 0;
        result_bus.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (served != hold_off_asked)
            begin
                served = hold_off_asked;
                result_bus.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            result_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Check every joint word taken from the block
    always @(posedge clk)
    begin
        joint_result_t seen;
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            seen.position = result_bus.position;
            seen.words    = {result_bus.hyper_phase_out, result_bus.phase_out,
                             result_bus.torsion_out, result_bus.zero_yaw_out,
                             result_bus.zero_pitch_out, result_bus.curvature_out,
                             result_bus.bias_out};
            seen.mask     = result_bus.updated_mask;
            seen.last     = result_bus.last;
            sb.check_joint(seen);
        end
    end

    // Watchdog: count cycles with no handshake on any channel
    always @(posedge clk)
    begin
        if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready) ||
            (cfg_bus.valid && cfg_bus.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t ns: watchdog expired, no handshake for %0d cycles", $time, quiet_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic shape_item_t flat_shape(logic [cjd_pkg::FIELD_WIDTH-1:0] w,
                                               logic [cjd_pkg::CHANNELS-1:0] mask,
                                               logic rev, logic from_hyper);
        shape_item_t it;
        for (int c = 0; c < cjd_pkg::CHANNELS; c++)
            it.words[c] = w;
        it.mask       = mask;
        it.rev        = rev;
        it.from_hyper = from_hyper;
        return it;
    endfunction

    // Distinct word per channel, so a misrouted channel shows up
    function automatic shape_item_t spread_shape(logic [cjd_pkg::FIELD_WIDTH-1:0] base,
                                                 logic [cjd_pkg::CHANNELS-1:0] mask,
                                                 logic rev, logic from_hyper);
        shape_item_t it;
        it = flat_shape(base, mask, rev, from_hyper);
        for (int c = 0; c < cjd_pkg::CHANNELS; c++)
            it.words[c] = base ^ (cjd_pkg::FIELD_WIDTH'(c + 1) << 28);
        return it;
    endfunction

    // Random word with extremes mixed in; full masks favoured to keep the chain busy
    function automatic shape_item_t random_shape();
        shape_item_t it;
        int          pick;
        for (int c = 0; c < cjd_pkg::CHANNELS; c++)
        begin
            case ($urandom_range(7))
                0:       it.words[c] = 32'h8000_0000;
                1:       it.words[c] = 32'h7fff_ffff;
                2:       it.words[c] = 32'h0000_0000;
                3:       it.words[c] = 32'hffff_ffff;
                default: it.words[c] = $urandom;
            endcase
        end
        pick = $urandom_range(9);
        if (pick < 4)
            it.mask = '1;
        else if (pick == 4)
            it.mask = '0;
        else
            it.mask = cjd_pkg::CHANNELS'($urandom_range(127));
        it.rev        = 1'($urandom_range(1));
        it.from_hyper = 1'($urandom_range(1));
        return it;
    endfunction

    // Offer one word after a random gap and hold it until taken
    task automatic offer_shape(input shape_item_t it);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            item_bus.valid <= 1'b0;
            @(posedge clk);
        end
        item_bus.valid                <= 1'b1;
        item_bus.bias_value           <= it.words[0];
        item_bus.curvature_value      <= it.words[1];
        item_bus.curvature_zero_pitch <= it.words[2];
        item_bus.curvature_zero_yaw   <= it.words[3];
        item_bus.torsion_value        <= it.words[4];
        item_bus.phase_value          <= it.words[5];
        item_bus.hyper_phase_value    <= it.words[6];
        item_bus.channel_mask         <= it.mask;
        item_bus.reverse_order        <= it.rev;
        item_bus.phase_from_hyper     <= it.from_hyper;
        do @(posedge clk); while (!item_bus.ready);
        sb.note_shape(it);
    endtask

    // Drop valid and wait until every outstanding joint word has come out
    task automatic drain_results();
        item_bus.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
    endtask

    // Write joint count and hold length, and optionally poke the undecoded indexes
    task automatic program_chain(input logic [cjd_pkg::CFG_WIDTH-1:0] joints,
                                 input logic [cjd_pkg::CFG_WIDTH-1:0] hold, input bit poke_spare);
        logic [cjd_pkg::CFG_INDEX_WIDTH-1:0] idx [4];
        logic [cjd_pkg::CFG_WIDTH-1:0]       val [4];
        int                                  n;
        idx[0] = cjd_pkg::REG_JOINT_COUNT;
        val[0] = joints;
        idx[1] = cjd_pkg::REG_HOLD_LENGTH;
        val[1] = hold;
        idx[2] = REG_SPARE_A;
        val[2] = cjd_pkg::CFG_WIDTH'($urandom);
        idx[3] = REG_SPARE_B;
        val[3] = cjd_pkg::CFG_WIDTH'($urandom);
        n = poke_spare ? 4 : 2;
        for (int i = 0; i < n; i++)
        begin
            cfg_bus.valid <= 1'b1;
            cfg_bus.index <= idx[i];
            cfg_bus.data  <= val[i];
            do @(posedge clk); while (!cfg_bus.ready);
            sb.write_reg(idx[i], val[i]);
        end
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [cjd_pkg::CFG_WIDTH-1:0] joints,
                             input logic [cjd_pkg::CFG_WIDTH-1:0] hold,
                             input int send_pct, input int recv_pct, input int count);
        program_chain(joints, hold, 1'b0);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        repeat (count) offer_shape(random_shape());
        drain_results();
    endtask

    initial
    begin
        rst_n                         = 1'b0;
        send_idle_pct                 = 0;
        recv_stall_pct                = 0;
        hold_off_asked                = 0;
        item_bus.valid                = 1'b0;
        item_bus.bias_value           = '0;
        item_bus.curvature_value      = '0;
        item_bus.curvature_zero_pitch = '0;
        item_bus.curvature_zero_yaw   = '0;
        item_bus.torsion_value        = '0;
        item_bus.phase_value          = '0;
        item_bus.hyper_phase_value    = '0;
        item_bus.channel_mask         = '0;
        item_bus.reverse_order        = 1'b0;
        item_bus.phase_from_hyper     = 1'b0;
        cfg_bus.valid                 = 1'b0;
        cfg_bus.index                 = cjd_pkg::REG_JOINT_COUNT;
        cfg_bus.data                  = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: sixteen joints, long hold
        offer_shape(flat_shape(32'h7fff_ffff, '1, 1'b0, 1'b0));
        offer_shape(flat_shape(32'h8000_0000, '1, 1'b1, 1'b1));
        drain_results();

        // Short chain, unit hold, undecoded indexes written too
        program_chain(6'd4, 6'd1, 1'b1);
        offer_shape(flat_shape(32'hffff_ffff, '1, 1'b0, 1'b0));
        offer_shape(flat_shape(32'h0000_0000, '1, 1'b1, 1'b0));
        offer_shape(spread_shape(32'h0a0b_0c0d, '1, 1'b0, 1'b1));
        offer_shape(spread_shape(32'h0234_5678, '1, 1'b1, 1'b0));
        for (int c = 0; c < cjd_pkg::CHANNELS; c++)
            offer_shape(spread_shape(32'h0000_1100 * (c + 1), cjd_pkg::CHANNELS'(1) << c,
                                     c[0], c[1]));
        offer_shape(flat_shape(32'h5a5a_5a5a, '0, 1'b0, 1'b1));
        offer_shape(flat_shape(32'h8000_0000, '1, 1'b1, 1'b1));
        offer_shape(flat_shape(32'h7fff_ffff, '1, 1'b0, 1'b0));
        offer_shape(spread_shape(32'h0eed_beef, '1, 1'b0, 1'b1));
        offer_shape(spread_shape(32'h0123_4567, '1, 1'b1, 1'b0));
        offer_shape(spread_shape(32'h0fed_cba9, '1, 1'b0, 1'b0));
        drain_results();

        // Random phases across the register range, zero and saturating values among them
        run_phase(6'd3,  6'd1,  0,  0,  12);
        run_phase(6'd32, 6'd32, 45, 0,  10);
        run_phase(6'd63, 6'd63, 0,  45, 8);
        run_phase(6'd0,  6'd0,  17, 17, 12);
        run_phase(6'd2,  6'd3,  0,  0,  15);
        // Grow the chain: joints left alone meanwhile must keep their old words
        run_phase(6'd9,  6'd3,  0,  45, 15);

        // Back-pressure: receiver holds off while words keep coming, then sender pauses
        program_chain(6'd6, 6'd2, 1'b1);
        send_idle_pct  = 17;
        recv_stall_pct = 17;
        hold_off_asked = hold_off_asked + 1;
        repeat (15) offer_shape(random_shape());
        drain_results();
        repeat (10) offer_shape(random_shape());
        drain_results();

        run_phase(6'd1,  6'd5,  45, 0,  15);

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
